// File: hw/rtl/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg: shared types and constants of the RGB contrast stretch
// Sample width, configuration register indexes, command codes and the
// control bundle that the back end drives into its channel lanes.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned FIELD_LANES = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  // Signed width of tmin*den + (v - lo)*(tmax - tmin).
  localparam int unsigned NUM_W       = 2 * (SAMPLE_W + 1) + 1;
  localparam int unsigned STEP_W      = $clog2(SAMPLE_W);

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_MAX = CFG_IDX_W'(1);

  localparam logic CMD_GATHER = 1'b0;
  localparam logic CMD_MAP    = 1'b1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic load;   // compute numerator and classify
    logic step;   // one quotient bit
  } lane_ctrl_t;

endpackage

// File: hw/rtl/rgb_contrast_stretch_top.sv
// ----------------------------------------------------------------------------
// rgb_contrast_stretch_top: per-channel min-max contrast stretch
// An image is streamed twice. Gather items (command 0) track the minimum and
// maximum of each channel; frame_start reloads both from that pixel. Map
// items (command 1) each give one result item with every channel remapped
// to target_min + (v - min) * (target_max - target_min) / (max - min),
// truncated toward zero and clamped to 0..255. A flat channel gives
// target_min and sets its bit in flat_channels.
// Channels: input and output use valid/ready; the config port writes
// target_min (index 0) and target_max (index 1) and is always ready.
// Gather items are taken one per cycle, as long as the map queue has room.
// A map item passes the back end in order: the pop loads it, ST_MUL forms the
// numerator, ST_DIV runs the bit-serial divider (one quotient bit per cycle,
// all channels in parallel) and ST_DONE loads the output register.
// A two-entry queue decouples input from the divider.
// Reset clears statistics to zero, sets targets to 0 and 255, empties the
// queue. A stalled receiver holds the result; the queue then fills and input
// ready drops.
// ----------------------------------------------------------------------------
module rgb_contrast_stretch_top import rcs_pkg::*; #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SAMPLE_W-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic                 frame_start_i,
  input  logic [SAMPLE_W-1:0]  in_red_i,
  input  logic [SAMPLE_W-1:0]  in_green_i,
  input  logic [SAMPLE_W-1:0]  in_blue_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SAMPLE_W-1:0]  out_red_o,
  output logic [SAMPLE_W-1:0]  out_green_o,
  output logic [SAMPLE_W-1:0]  out_blue_o,
  output logic [FIELD_LANES-1:0] flat_channels_o
);

  localparam int unsigned LANES   = (CHANNELS < FIELD_LANES) ? CHANNELS : FIELD_LANES;
  localparam int unsigned ENTRY_W = 3 * LANES * SAMPLE_W;

  sample_t                   tmin_q, tmax_q;
  sample_t [FIELD_LANES-1:0] in_field, out_field;
  logic    [FIELD_LANES-1:0] out_flat_field;
  sample_t [LANES-1:0]       in_samp, out_samp;
  logic    [LANES-1:0]       out_flat;
  logic                      push_valid, push_ready, pop_valid, pop_ready;
  logic    [ENTRY_W-1:0]     push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmin_q <= '0;
      tmax_q <= SAMPLE_MAX;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_TARGET_MIN) tmin_q <= cfg_data_i;
      if (cfg_index_i == REG_TARGET_MAX) tmax_q <= cfg_data_i;
    end
  end

  assign in_field = {in_blue_i, in_green_i, in_red_i};

  for (genvar k = 0; k < FIELD_LANES; k++) begin : g_field
    if (k < LANES) begin : g_used
      assign in_samp[k]        = in_field[k];
      assign out_field[k]      = out_samp[k];
      assign out_flat_field[k] = out_flat[k];
    end else begin : g_unused
      assign out_field[k]      = '0;
      assign out_flat_field[k] = 1'b0;
    end
  end

  rcs_front #(.LANES(LANES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .frame_start_i (frame_start_i),
    .sample_i      (in_samp),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  rcs_fifo #(.WIDTH(ENTRY_W), .DEPTH(2)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rcs_back #(.LANES(LANES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .tmin_i       (tmin_q),
    .tmax_i       (tmax_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_sample_o (out_samp),
    .out_flat_o   (out_flat)
  );

  assign out_red_o       = out_field[0];
  assign out_green_o     = out_field[1];
  assign out_blue_o      = out_field[2];
  assign flat_channels_o = out_flat_field;

endmodule

// File: hw/rtl/rcs_fifo.sv
// ----------------------------------------------------------------------------
// rcs_fifo: small register queue between front and back end
// Holds map items with the statistics captured at their acceptance.
// ----------------------------------------------------------------------------
module rcs_fifo #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/rcs_front.sv
// ----------------------------------------------------------------------------
// rcs_front: input side of the contrast stretch
// Gather items update the per-channel minimum and maximum; map items are
// queued together with the statistics in force when they arrive.
// ----------------------------------------------------------------------------
module rcs_front import rcs_pkg::*; #(
  parameter int unsigned LANES = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic                              frame_start_i,
  input  sample_t [LANES-1:0]               sample_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output logic [3*LANES*SAMPLE_W-1:0]       push_data_o
);

  sample_t [LANES-1:0] min_q, min_d, max_q, max_d;
  logic                gather;

  assign in_ready_o   = push_ready_i;
  assign gather       = in_valid_i && push_ready_i && (command_i == CMD_GATHER);
  assign push_valid_o = in_valid_i && (command_i == CMD_MAP);
  assign push_data_o  = {sample_i, min_q, max_q};

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    for (int k = 0; k < LANES; k++) begin
      if (gather) begin
        if (frame_start_i) begin
          min_d[k] = sample_i[k];
          max_d[k] = sample_i[k];
        end else begin
          if (sample_i[k] < min_q[k]) min_d[k] = sample_i[k];
          if (sample_i[k] > max_q[k]) max_d[k] = sample_i[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

endmodule

// File: hw/rtl/rcs_lane.sv
// ----------------------------------------------------------------------------
// rcs_lane: remap of one channel sample
// Forms the exact numerator combinationally and captures it on load, then finds
// the clamped quotient with a restoring divider that yields one bit per cycle.
// ----------------------------------------------------------------------------
module rcs_lane import rcs_pkg::*; (
  input  logic       clk_i,
  input  lane_ctrl_t ctrl_i,
  input  sample_t    sample_i,
  input  sample_t    lo_i,
  input  sample_t    hi_i,
  input  sample_t    tmin_i,
  input  sample_t    tmax_i,
  output sample_t    result_o,
  output logic       flat_o
);

  localparam int unsigned DIFF_W = SAMPLE_W + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned BASE_W = 2 * SAMPLE_W;

  // The statistics always satisfy lo <= hi, so den = hi - lo is never negative.
  sample_t                   den;
  logic signed [DIFF_W-1:0]  diff, span;
  logic signed [PROD_W-1:0]  prod;
  logic        [BASE_W-1:0]  base;
  logic signed [NUM_W-1:0]   num;
  logic        [NUM_W-2:0]   limit;

  sample_t           den_q, rem_q, rem_d, low_q, low_d, quot_q, quot_d;
  logic              flat_q, neg_q, sat_q;
  logic [SAMPLE_W:0] trial;

  assign den   = hi_i - lo_i;
  assign diff  = $signed({1'b0, sample_i}) - $signed({1'b0, lo_i});
  assign span  = $signed({1'b0, tmax_i}) - $signed({1'b0, tmin_i});
  assign prod  = diff * span;
  assign base  = tmin_i * den;
  assign num   = $signed({{(NUM_W - BASE_W){1'b0}}, base})
               + $signed({{(NUM_W - PROD_W){prod[PROD_W-1]}}, prod});
  assign limit = (NUM_W - 1)'({den, {SAMPLE_W{1'b0}}});

  assign trial = {rem_q, low_q[SAMPLE_W-1]};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    if (ctrl_i.load) begin
      rem_d  = num[BASE_W-1:SAMPLE_W];
      low_d  = num[SAMPLE_W-1:0];
      quot_d = '0;
    end else if (ctrl_i.step) begin
      low_d = {low_q[SAMPLE_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d  = SAMPLE_W'(trial - {1'b0, den_q});
        quot_d = {quot_q[SAMPLE_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[SAMPLE_W-1:0];
        quot_d = {quot_q[SAMPLE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      den_q  <= den;
      flat_q <= (den == '0);
      neg_q  <= num[NUM_W-1];
      sat_q  <= (num[NUM_W-2:0] >= limit);
    end
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  always_comb begin
    priority if (flat_q) begin
      result_o = tmin_i;
    end else if (neg_q) begin
      result_o = '0;
    end else if (sat_q) begin
      result_o = SAMPLE_MAX;
    end else begin
      result_o = quot_q;
    end
  end

  assign flat_o = flat_q;

endmodule

// File: hw/rtl/rcs_back.sv
// ----------------------------------------------------------------------------
// rcs_back: execution side of the contrast stretch
// Takes one queued map item at a time, runs the channel lanes through
// numerator and division steps, and holds the result in an output register.
// ----------------------------------------------------------------------------
module rcs_back import rcs_pkg::*; #(
  parameter int unsigned LANES = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  logic [3*LANES*SAMPLE_W-1:0] pop_data_i,
  input  sample_t                     tmin_i,
  input  sample_t                     tmax_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sample_t [LANES-1:0]         out_sample_o,
  output logic [LANES-1:0]            out_flat_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  sample_t [LANES-1:0] samp_q, lo_q, hi_q, res;
  logic [LANES-1:0]    flat;
  logic                out_valid_q, out_valid_d, load_out;
  sample_t [LANES-1:0] out_sample_q;
  logic [LANES-1:0]    out_flat_q;
  lane_ctrl_t          ctrl;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign ctrl.load   = (state_q == ST_MUL);
  assign ctrl.step   = (state_q == ST_DIV);
  assign load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_d = (out_valid_q && !out_ready_i) || load_out;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(SAMPLE_W - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      {samp_q, lo_q, hi_q} <= pop_data_i;
    end
    if (load_out) begin
      out_sample_q <= res;
      out_flat_q   <= flat;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    rcs_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .sample_i (samp_q[k]),
      .lo_i     (lo_q[k]),
      .hi_i     (hi_q[k]),
      .tmin_i   (tmin_i),
      .tmax_i   (tmax_i),
      .result_o (res[k]),
      .flat_o   (flat[k])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_flat_o   = out_flat_q;

endmodule

// File: hw/rtl/rcs_checker.sv
// ----------------------------------------------------------------------------
// rcs_checker: port-level checks of the contrast stretch
// Tracks map items in flight and the target_min register from the ports.
// ----------------------------------------------------------------------------
module rcs_checker import rcs_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic [CFG_IDX_W-1:0]   cfg_index_i,
  input logic [SAMPLE_W-1:0]    cfg_data_i,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   command_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_W-1:0]    out_red_o,
  input logic [SAMPLE_W-1:0]    out_green_o,
  input logic [SAMPLE_W-1:0]    out_blue_o,
  input logic [FIELD_LANES-1:0] flat_channels_o
);

  logic [3:0] pend_q;
  sample_t    tmin_q;
  logic       map_acc, out_acc;

  assign map_acc = in_valid_i && in_ready_o && (command_i == CMD_MAP);
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      tmin_q <= '0;
    end else begin
      if (map_acc && !out_acc) begin
        pend_q <= pend_q + 4'd1;
      end else if (out_acc && !map_acc) begin
        pend_q <= pend_q - 4'd1;
      end
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_TARGET_MIN)) begin
        tmin_q <= cfg_data_i;
      end
    end
  end

  // A held result must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o
      && $stable({out_red_o, out_green_o, out_blue_o, flat_channels_o}))
    else $error("result changed while stalled");

  // Every result item belongs to an earlier accepted map item.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 4'd0)
    else $error("result without a pending map item");

  // A flat red channel maps to target_min.
  a_flat_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flat_channels_o[0] |-> out_red_o == tmin_q)
    else $error("flat channel did not give target_min");

endmodule

bind rgb_contrast_stretch_top rcs_checker u_rcs_checker (.*);

// File: tb/rgb_contrast_stretch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_contrast_stretch_checker: scoreboard of the RGB contrast stretch
// Watches the config, input and output channels, tracks the channel
// statistics and targets, predicts the remapped pixel of every map item and
// compares each result item with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rgb_contrast_stretch_checker import rcs_pkg::*; #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SAMPLE_W-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   command_i,
  input  logic                   frame_start_i,
  input  logic [SAMPLE_W-1:0]    in_red_i,
  input  logic [SAMPLE_W-1:0]    in_green_i,
  input  logic [SAMPLE_W-1:0]    in_blue_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [SAMPLE_W-1:0]    out_red_i,
  input  logic [SAMPLE_W-1:0]    out_green_i,
  input  logic [SAMPLE_W-1:0]    out_blue_i,
  input  logic [FIELD_LANES-1:0] flat_channels_i,
  output int                     pending_o,
  output int                     errors_o
);

  typedef struct {
    sample_t                level [FIELD_LANES];
    logic [FIELD_LANES-1:0] flat;
  } stretched_px_t;

  stretched_px_t stretched_q [$];
  sample_t       lane_lo [FIELD_LANES];
  sample_t       lane_hi [FIELD_LANES];
  sample_t       target_lo;
  sample_t       target_hi;
  int            mismatches;

  // Exact rational remap, truncated toward zero, then clamped to the sample range.
  function automatic sample_t stretch_sample(input sample_t v, lo, hi, tlo, thi);
    longint span;
    longint num;
    longint q;
    span = longint'(hi) - longint'(lo);
    if (span == 0) begin
      q = longint'(tlo);
    end else begin
      num = longint'(tlo) * span
          + (longint'(v) - longint'(lo)) * (longint'(thi) - longint'(tlo));
      if (span < 0) begin
        span = -span;
        num  = -num;
      end
      q = num / span;
    end
    if (q < 0) q = 0;
    if (q > longint'(SAMPLE_MAX)) q = longint'(SAMPLE_MAX);
    return sample_t'(q);
  endfunction

  function automatic void check_field(input string field,
                                      input logic [SAMPLE_W-1:0] want, got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stretched_px_t want;
    sample_t       px [FIELD_LANES];
    if (!rst_ni) begin
      for (int k = 0; k < FIELD_LANES; k++) begin
        lane_lo[k] = '0;
        lane_hi[k] = '0;
      end
      target_lo = '0;
      target_hi = SAMPLE_MAX;
      stretched_q.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (stretched_q.size() == 0) begin
          mismatches++;
          $display("%0t: result item with none expected: r=%0d g=%0d b=%0d flat=%b",
                   $time, out_red_i, out_green_i, out_blue_i, flat_channels_i);
        end else begin
          want = stretched_q.pop_front();
          check_field("out_red", want.level[0], out_red_i);
          check_field("out_green", want.level[1], out_green_i);
          check_field("out_blue", want.level[2], out_blue_i);
          check_field("flat_channels", SAMPLE_W'(want.flat), SAMPLE_W'(flat_channels_i));
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_TARGET_MIN) begin
          target_lo = cfg_data_i;
        end else if (cfg_index_i == REG_TARGET_MAX) begin
          target_hi = cfg_data_i;
        end
      end

      if (in_valid_i && in_ready_i) begin
        px[0] = in_red_i;
        px[1] = in_green_i;
        px[2] = in_blue_i;
        if (command_i == CMD_GATHER) begin
          for (int k = 0; k < FIELD_LANES; k++) begin
            if (k < CHANNELS) begin
              if (frame_start_i) begin
                lane_lo[k] = px[k];
                lane_hi[k] = px[k];
              end else begin
                if (px[k] < lane_lo[k]) lane_lo[k] = px[k];
                if (px[k] > lane_hi[k]) lane_hi[k] = px[k];
              end
            end
          end
        end else begin
          // Lanes past the channel count stay at zero with a clear flat bit.
          for (int k = 0; k < FIELD_LANES; k++) begin
            if (k < CHANNELS) begin
              want.level[k] = stretch_sample(px[k], lane_lo[k], lane_hi[k],
                                             target_lo, target_hi);
              want.flat[k]  = (lane_lo[k] == lane_hi[k]);
            end else begin
              want.level[k] = '0;
              want.flat[k]  = 1'b0;
            end
          end
          stretched_q.push_back(want);
        end
      end

      pending_o <= stretched_q.size();
      errors_o  <= mismatches;
    end
  end

endmodule

// File: tb/rgb_contrast_stretch_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_contrast_stretch_top_tb: stimulus and verdict for the contrast stretch
// Streams frames twice (gather, then map) under a series of target settings,
// with random idling on both sides, a long output hold-off that backs up the
// input, and a drain before every register write. The checker beside the
// block predicts and compares every result item.
// ----------------------------------------------------------------------------
module rgb_contrast_stretch_top_tb;
  import rcs_pkg::*;

  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned ITEM_TARGET    = 1550;
  localparam int unsigned CALM_AFTER     = 1420;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT    = 2000;

  // Register indexes the block decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_TARGET_MAX + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  typedef logic [FIELD_LANES-1:0][SAMPLE_W-1:0] pixel_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = REG_TARGET_MIN;
  logic [SAMPLE_W-1:0]    cfg_data_i    = '0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_ready_o;
  logic                   command_i     = CMD_GATHER;
  logic                   frame_start_i = 1'b0;
  logic [SAMPLE_W-1:0]    in_red_i      = '0;
  logic [SAMPLE_W-1:0]    in_green_i    = '0;
  logic [SAMPLE_W-1:0]    in_blue_i     = '0;
  logic                   out_valid_o;
  logic                   out_ready_i   = 1'b0;
  logic [SAMPLE_W-1:0]    out_red_o;
  logic [SAMPLE_W-1:0]    out_green_o;
  logic [SAMPLE_W-1:0]    out_blue_o;
  logic [FIELD_LANES-1:0] flat_channels_o;

  int results_pending;
  int mismatch_count;
  int pixels_sent  = 0;
  bit calm         = 1'b0;
  bit hold_off_req = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rgb_contrast_stretch_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .frame_start_i  (frame_start_i),
    .in_red_i       (in_red_i),
    .in_green_i     (in_green_i),
    .in_blue_i      (in_blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .flat_channels_o(flat_channels_o)
  );

  rgb_contrast_stretch_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .frame_start_i  (frame_start_i),
    .in_red_i       (in_red_i),
    .in_green_i     (in_green_i),
    .in_blue_i      (in_blue_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_red_i      (out_red_o),
    .out_green_i    (out_green_o),
    .out_blue_i     (out_blue_o),
    .flat_channels_i(flat_channels_o),
    .pending_o      (results_pending),
    .errors_o       (mismatch_count)
  );

  function automatic pixel_t make_rgb(input sample_t r, g, b);
    pixel_t px;
    px[0] = r;
    px[1] = g;
    px[2] = b;
    return px;
  endfunction

  function automatic sample_t pick_level();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return SAMPLE_MAX;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offers one pixel and returns once it is accepted; valid stays high unless
  // an idle burst follows.
  task automatic offer_pixel(input logic cmd, input logic fs, input pixel_t px);
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    frame_start_i <= fs;
    in_red_i      <= px[0];
    in_green_i    <= px[1];
    in_blue_i     <= px[2];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pixels_sent++;
    if (pixels_sent >= CALM_AFTER) calm = 1'b1;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Stops offering until every predicted result has arrived, then lets the
  // block settle before returning.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic await_cfg();
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic write_targets(input sample_t lo, input sample_t hi);
    cfg_valid_i <= 1'b1;
    if ($urandom_range(0, 3) == 0) begin
      cfg_index_i <= $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
      cfg_data_i  <= sample_t'($urandom);
      await_cfg();
    end
    cfg_index_i <= REG_TARGET_MIN;
    cfg_data_i  <= lo;
    await_cfg();
    cfg_index_i <= REG_TARGET_MAX;
    cfg_data_i  <= hi;
    await_cfg();
    cfg_valid_i <= 1'b0;
  endtask

  // One frame: a gather pass over a few pixels drawn from per-channel bands,
  // then a map pass over the same pixels with some strays and noise mixed in.
  task automatic run_frame();
    pixel_t frame_px [$];
    pixel_t px;
    int     band_lo [FIELD_LANES];
    int     band_span [FIELD_LANES];
    int     npx;
    bit     skip_start;
    npx = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    skip_start = ($urandom_range(0, 11) == 0);
    for (int k = 0; k < FIELD_LANES; k++) begin
      case ($urandom_range(0, 4))
        0: begin
          band_lo[k]   = $urandom_range(0, 255);
          band_span[k] = 0;
        end
        1: begin
          band_lo[k]   = $urandom_range(0, 248);
          band_span[k] = $urandom_range(1, 7);
        end
        2: begin
          band_lo[k]   = 0;
          band_span[k] = 255;
        end
        default: begin
          band_lo[k]   = $urandom_range(0, 255);
          band_span[k] = $urandom_range(0, 255 - band_lo[k]);
        end
      endcase
    end
    for (int i = 0; i < npx; i++) begin
      for (int k = 0; k < FIELD_LANES; k++)
        px[k] = sample_t'(band_lo[k] + $urandom_range(0, band_span[k]));
      frame_px.push_back(px);
      offer_pixel(CMD_GATHER, (i == 0) ? !skip_start : ($urandom_range(0, 31) == 0), px);
    end
    for (int i = 0; i < npx; i++) begin
      px = ($urandom_range(0, 7) == 0) ? pixel_t'($urandom) : frame_px[i];
      offer_pixel(CMD_MAP, $urandom_range(0, 7) == 0, px);
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4))
        offer_pixel($urandom_range(0, 1) ? CMD_MAP : CMD_GATHER,
                    $urandom_range(0, 1), pixel_t'($urandom));
    end
  endtask

  initial begin : receiver
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o)
          || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int      phase;
    sample_t tlo;
    sample_t thi;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Map straight after reset: every channel is flat at zero.
    offer_pixel(CMD_MAP, 1'b0, make_rgb(8'd255, 8'd0, 8'd128));
    // Gather without a frame start grows from the reset statistics.
    offer_pixel(CMD_GATHER, 1'b0, make_rgb(8'd10, 8'd200, 8'd0));
    // Frame start on a map item is ignored.
    offer_pixel(CMD_MAP, 1'b1, make_rgb(8'd5, 8'd255, 8'd77));
    offer_pixel(CMD_MAP, 1'b0, make_rgb(8'd20, 8'd100, 8'd0));
    offer_pixel(CMD_GATHER, 1'b1, make_rgb(8'd50, 8'd0, 8'd255));
    offer_pixel(CMD_GATHER, 1'b0, make_rgb(8'd100, 8'd255, 8'd255));
    offer_pixel(CMD_GATHER, 1'b0, make_rgb(8'd75, 8'd128, 8'd255));
    // Samples below and above the gathered range extrapolate and clamp.
    offer_pixel(CMD_MAP, 1'b0, make_rgb(8'd0, 8'd0, 8'd255));
    offer_pixel(CMD_MAP, 1'b0, make_rgb(8'd255, 8'd255, 8'd0));
    offer_pixel(CMD_MAP, 1'b0, make_rgb(8'd50, 8'd255, 8'd255));
    offer_pixel(CMD_MAP, 1'b0, make_rgb(8'd99, 8'd127, 8'd77));
    drain_block();
    // Inverted targets give a falling map.
    write_targets(8'd200, 8'd40);
    offer_pixel(CMD_MAP, 1'b0, make_rgb(8'd50, 8'd0, 8'd255));
    offer_pixel(CMD_MAP, 1'b0, make_rgb(8'd100, 8'd255, 8'd0));
    offer_pixel(CMD_MAP, 1'b1, make_rgb(8'd255, 8'd1, 8'd254));
    offer_pixel(CMD_MAP, 1'b0, make_rgb(8'd0, 8'd128, 8'd3));
    offer_pixel(CMD_MAP, 1'b0, make_rgb(8'd51, 8'd64, 8'd255));
    drain_block();

    // Hold the output off long enough for the input to back up.
    hold_off_req = 1'b1;
    repeat (24) offer_pixel(CMD_MAP, $urandom_range(0, 1), pixel_t'($urandom));
    drain_block();

    phase = 0;
    while (pixels_sent < ITEM_TARGET) begin
      case (phase)
        0: begin tlo = '0;         thi = '0;         end
        1: begin tlo = SAMPLE_MAX; thi = SAMPLE_MAX; end
        2: begin tlo = SAMPLE_MAX; thi = '0;         end
        3: begin tlo = '0;         thi = SAMPLE_MAX; end
        4: begin tlo = '0;         thi = 8'd1;       end
        5: begin tlo = SAMPLE_MAX; thi = 8'd254;     end
        default: begin
          tlo = pick_level();
          thi = pick_level();
        end
      endcase
      phase++;
      write_targets(tlo, thi);
      repeat ($urandom_range(1, 3)) run_frame();
      drain_block();
    end

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
